/* hdl/pointer_gesture_recognizer_assert.svh */
// Assertion macros used by the gesture sequencer module.
`ifndef POINTER_GESTURE_RECOGNIZER_ASSERT_SVH
`define POINTER_GESTURE_RECOGNIZER_ASSERT_SVH

// Check that expr holds at every clock edge outside reset.
`define PGR_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Check that expr holds at every edge where cond holds.
`define PGR_ASSERT_IMPLY(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

`endif

/* hdl/pgr_pkg.sv */
// Shared types, codes and constants of the pointer gesture recognizer.
package pgr_pkg;

   // event opcodes
   localparam logic [1:0] OP_PRESS   = 2'd0;
   localparam logic [1:0] OP_MOVE    = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   localparam logic [1:0] BTN_RIGHT = 2'd2;

   // gesture kinds
   localparam logic [2:0] K_NONE       = 3'd0;
   localparam logic [2:0] K_CLICK      = 3'd1;
   localparam logic [2:0] K_DOUBLE     = 3'd2;
   localparam logic [2:0] K_RIGHT      = 3'd3;
   localparam logic [2:0] K_DRAG_START = 3'd4;
   localparam logic [2:0] K_DRAG       = 3'd5;
   localparam logic [2:0] K_DRAG_END   = 3'd6;

   localparam logic [1:0] CNT_NONE   = 2'd0;
   localparam logic [1:0] CNT_SINGLE = 2'd1;
   localparam logic [1:0] CNT_DOUBLE = 2'd2;

   // register indexes
   localparam logic [1:0] REG_DRAG_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_DC_WINDOW      = 2'd1;
   localparam logic [1:0] REG_DC_TOLERANCE   = 2'd2;
   localparam logic [1:0] REG_DPI_SCALE      = 2'd3;

   localparam logic [11:0] DRAG_THRESHOLD_RESET = 12'd64;
   localparam logic [11:0] DC_WINDOW_RESET      = 12'd400;
   localparam logic [11:0] DC_TOLERANCE_RESET   = 12'd64;
   localparam logic [10:0] DPI_SCALE_RESET      = 11'd256;

   // delta slots computed by the divider
   localparam int N_DELTAS = 4;
   localparam logic [1:0] DIV_TDX = 2'd0;
   localparam logic [1:0] DIV_TDY = 2'd1;
   localparam logic [1:0] DIV_SDX = 2'd2;
   localparam logic [1:0] DIV_SDY = 2'd3;

   // quotient bit 15 set means the logical delta is out of range
   localparam logic [3:0]  DIV_TOP = 4'd15;
   localparam logic [15:0] SAT_POS = 16'h7FFF;
   localparam logic [15:0] SAT_NEG = 16'h8000;

   typedef struct packed {
      logic [11:0] drag_threshold;
      logic [11:0] window;
      logic [11:0] tolerance;
      logic [10:0] dpi_scale;
      logic [10:0] scale_nz;
   } cfg_type;

   typedef struct packed {
      logic               start;
      logic signed [16:0] diff;
      logic [10:0]        scale;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] value;
   } div_rsp_type;

endpackage

/* hdl/pgr_csr.sv */
// Configuration registers behind the APB-style port.
module pgr_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [3:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output pgr_pkg::cfg_type     cfg
);

   logic [11:0] thr_ff, thr_in;
   logic [11:0] win_ff, win_in;
   logic [11:0] tol_ff, tol_in;
   logic [10:0] scale_ff, scale_in;
   logic        write_en;

   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      thr_in   = thr_ff;
      win_in   = win_ff;
      tol_in   = tol_ff;
      scale_in = scale_ff;
      if (write_en) begin
         unique case (csr_paddr[3:2])
            pgr_pkg::REG_DRAG_THRESHOLD: thr_in   = csr_pwdata[11:0];
            pgr_pkg::REG_DC_WINDOW:      win_in   = csr_pwdata[11:0];
            pgr_pkg::REG_DC_TOLERANCE:   tol_in   = csr_pwdata[11:0];
            pgr_pkg::REG_DPI_SCALE:      scale_in = csr_pwdata[10:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         pgr_pkg::REG_DRAG_THRESHOLD: csr_prdata = {20'd0, thr_ff};
         pgr_pkg::REG_DC_WINDOW:      csr_prdata = {20'd0, win_ff};
         pgr_pkg::REG_DC_TOLERANCE:   csr_prdata = {20'd0, tol_ff};
         pgr_pkg::REG_DPI_SCALE:      csr_prdata = {21'd0, scale_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= pgr_pkg::DRAG_THRESHOLD_RESET;
         win_ff   <= pgr_pkg::DC_WINDOW_RESET;
         tol_ff   <= pgr_pkg::DC_TOLERANCE_RESET;
         scale_ff <= pgr_pkg::DPI_SCALE_RESET;
      end else begin
         thr_ff   <= thr_in;
         win_ff   <= win_in;
         tol_ff   <= tol_in;
         scale_ff <= scale_in;
      end
   end

   always_comb begin
      cfg.drag_threshold = thr_ff;
      cfg.window         = win_ff;
      cfg.tolerance      = tol_ff;
      cfg.dpi_scale      = scale_ff;
      // a zero scale acts as one
      cfg.scale_nz       = (scale_ff == 11'd0) ? 11'd1 : scale_ff;
   end

endmodule

/* hdl/pgr_div.sv */
// Bit-serial divider: screen delta to saturated logical delta.
module pgr_div (
   input  logic                  clock,
   input  logic                  reset,
   input  pgr_pkg::div_req_type  div_req,
   output pgr_pkg::div_rsp_type  div_rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        neg_ff, neg_in;
   logic [24:0] rem_ff, rem_in;
   logic [25:0] dvs_ff, dvs_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [14:0] q_ff, q_in;
   logic [15:0] value_ff, value_in;
   logic        ge;
   logic [14:0] q_next;
   logic [16:0] mag;

   assign ge     = {1'b0, rem_ff} >= dvs_ff;
   assign q_next = {q_ff[13:0], ge};
   assign mag    = div_req.diff[16] ? (17'd0 - div_req.diff) : div_req.diff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      cnt_in   = cnt_ff;
      q_in     = q_ff;
      value_in = value_ff;
      if (div_req.start) begin
         // numerator |d| * 256 + scale / 2 rounds to nearest, ties away from zero
         busy_in = 1'b1;
         neg_in  = div_req.diff[16];
         rem_in  = {1'b0, mag[15:0], 8'd0} + {15'd0, div_req.scale[10:1]};
         dvs_in  = {div_req.scale, 15'd0};
         cnt_in  = pgr_pkg::DIV_TOP;
         q_in    = 15'd0;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - dvs_ff[24:0];
         end
         dvs_in = dvs_ff >> 1;
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == pgr_pkg::DIV_TOP && ge) begin
            // quotient reaches 32768: clamp and stop early
            busy_in  = 1'b0;
            done_in  = 1'b1;
            value_in = neg_ff ? pgr_pkg::SAT_NEG : pgr_pkg::SAT_POS;
         end else begin
            q_in = q_next;
            if (cnt_ff == 4'd0) begin
               busy_in  = 1'b0;
               done_in  = 1'b1;
               value_in = neg_ff ? (16'd0 - {1'b0, q_next}) : {1'b0, q_next};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff   <= neg_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      cnt_ff   <= cnt_in;
      q_ff     <= q_in;
      value_ff <= value_in;
   end

   assign div_rsp.done  = done_ff;
   assign div_rsp.value = value_ff;

endmodule

/* hdl/pgr_seq.sv */
// Gesture sequencer: pointer state, shared multiplier and result register.
`include "pointer_gesture_recognizer_assert.svh"

module pgr_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  pgr_pkg::cfg_type      cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_opcode,
   input  logic signed [15:0]    req_pos_x,
   input  logic signed [15:0]    req_pos_y,
   input  logic [31:0]           req_time_ms,
   input  logic [1:0]            req_button,
   input  logic [3:0]            req_modifiers,
   input  logic                  req_visible,
   input  logic                  req_enabled,
   input  logic                  req_raw_consumed,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_event_kind,
   output logic                  rsp_handled,
   output logic                  rsp_last_of_run,
   output logic [1:0]            rsp_click_count,
   output logic signed [15:0]    rsp_step_dx,
   output logic signed [15:0]    rsp_step_dy,
   output logic signed [15:0]    rsp_total_dx,
   output logic signed [15:0]    rsp_total_dy,
   output logic [1:0]            rsp_event_button,
   output logic [3:0]            rsp_event_modifiers,
   output logic [31:0]           rsp_event_time_ms,
   output pgr_pkg::div_req_type  div_req,
   input  pgr_pkg::div_rsp_type  div_rsp
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DECIDE  = 4'd1;
   localparam logic [3:0] S_M0      = 4'd2;
   localparam logic [3:0] S_M1      = 4'd3;
   localparam logic [3:0] S_M2      = 4'd4;
   localparam logic [3:0] S_M3      = 4'd5;
   localparam logic [3:0] S_M4      = 4'd6;
   localparam logic [3:0] S_DIVGO   = 4'd7;
   localparam logic [3:0] S_DIVWAIT = 4'd8;
   localparam logic [3:0] S_FIN     = 4'd9;
   localparam logic [3:0] S_EMIT0   = 4'd10;
   localparam logic [3:0] S_EMIT1   = 4'd11;

   logic [3:0] state_ff, state_in;

   // captured input item
   logic [1:0]         in_op_ff, in_op_in;
   logic signed [15:0] in_x_ff, in_x_in;
   logic signed [15:0] in_y_ff, in_y_in;
   logic [31:0]        in_t_ff, in_t_in;
   logic [1:0]         in_btn_ff, in_btn_in;
   logic [3:0]         in_mods_ff, in_mods_in;
   logic               in_vis_ff, in_vis_in;
   logic               in_en_ff, in_en_in;
   logic               in_raw_ff, in_raw_in;

   // pointer state
   logic               pressed_ff, pressed_in;
   logic               dragging_ff, dragging_in;
   logic               captured_ff, captured_in;
   logic signed [15:0] press_x_ff, press_x_in;
   logic signed [15:0] press_y_ff, press_y_in;
   logic signed [15:0] move_x_ff, move_x_in;
   logic signed [15:0] move_y_ff, move_y_in;
   logic [1:0]         press_btn_ff, press_btn_in;
   logic [3:0]         press_mods_ff, press_mods_in;
   logic [31:0]        click_t_ff, click_t_in;
   logic signed [15:0] click_x_ff, click_x_in;
   logic signed [15:0] click_y_ff, click_y_in;

   // working registers
   logic               mode_click_ff, mode_click_in;
   logic               start_ff, start_in;
   logic [1:0]         k_ff, k_in;
   logic [15:0]        qt_ff [pgr_pkg::N_DELTAS];
   logic [15:0]        qt_in [pgr_pkg::N_DELTAS];
   logic signed [47:0] prod_ff, prod_in;
   logic [32:0]        acc_ff, acc_in;
   logic [2:0]         kind0_ff, kind0_in;
   logic [2:0]         kind1_ff, kind1_in;
   logic               two_ff, two_in;
   logic               handled_ff, handled_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_kind_ff, rsp_kind_in;
   logic               rsp_handled_ff, rsp_handled_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [1:0]         rsp_count_ff, rsp_count_in;
   logic [15:0]        rsp_sdx_ff, rsp_sdx_in;
   logic [15:0]        rsp_sdy_ff, rsp_sdy_in;
   logic [15:0]        rsp_tdx_ff, rsp_tdx_in;
   logic [15:0]        rsp_tdy_ff, rsp_tdy_in;
   logic [1:0]         rsp_btn_ff, rsp_btn_in;
   logic [3:0]         rsp_mods_ff, rsp_mods_in;
   logic [31:0]        rsp_t_ff, rsp_t_in;

   logic               req_take;
   logic               out_free;
   logic               emit_go;
   logic [2:0]         emit_kind;
   logic signed [16:0] dx_press, dy_press, dx_move, dy_move, dx_click, dy_click;
   logic signed [16:0] sq_a0, sq_a1;
   logic signed [23:0] mul_a, mul_b;
   logic signed [47:0] mul_p;
   logic [1:0]         k_last;
   logic               hit_drag, hit_click;
   logic [31:0]        dt;
   logic               in_window;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_go   = (state_ff == S_EMIT0 || state_ff == S_EMIT1) && out_free;
   assign emit_kind = (state_ff == S_EMIT1) ? kind1_ff : kind0_ff;

   assign dx_press = {in_x_ff[15], in_x_ff} - {press_x_ff[15], press_x_ff};
   assign dy_press = {in_y_ff[15], in_y_ff} - {press_y_ff[15], press_y_ff};
   assign dx_move  = {in_x_ff[15], in_x_ff} - {move_x_ff[15], move_x_ff};
   assign dy_move  = {in_y_ff[15], in_y_ff} - {move_y_ff[15], move_y_ff};
   assign dx_click = {in_x_ff[15], in_x_ff} - {click_x_ff[15], click_x_ff};
   assign dy_click = {in_y_ff[15], in_y_ff} - {click_y_ff[15], click_y_ff};
   assign sq_a0    = mode_click_ff ? dx_click : dx_press;
   assign sq_a1    = mode_click_ff ? dy_click : dy_press;

   // shared multiplier: squares, then threshold product, then its square
   always_comb begin
      unique case (state_ff)
         S_M0: begin
            mul_a = {{7{sq_a0[16]}}, sq_a0};
            mul_b = {{7{sq_a0[16]}}, sq_a0};
         end
         S_M1: begin
            mul_a = {{7{sq_a1[16]}}, sq_a1};
            mul_b = {{7{sq_a1[16]}}, sq_a1};
         end
         S_M2: begin
            mul_a = mode_click_ff ? {12'd0, cfg.tolerance} : {12'd0, cfg.drag_threshold};
            mul_b = mode_click_ff ? 24'sd1 : {13'd0, cfg.scale_nz};
         end
         S_M3: begin
            mul_a = prod_ff[23:0];
            mul_b = prod_ff[23:0];
         end
         default: begin
            mul_a = 24'sd0;
            mul_b = 24'sd0;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // distances compared squared; drag lhs scaled by 65536 to match Q3.8 scale squared
   assign hit_drag  = {acc_ff, 16'd0} >= {3'd0, prod_ff[45:0]};
   assign hit_click = {13'd0, acc_ff} <= prod_ff[45:0];
   assign dt        = in_t_ff - click_t_ff;
   assign in_window = dt <= {20'd0, cfg.window};
   assign k_last    = (in_op_ff == pgr_pkg::OP_MOVE) ? pgr_pkg::DIV_SDY : pgr_pkg::DIV_TDY;

   always_comb begin
      unique case (k_ff)
         pgr_pkg::DIV_TDX: div_req.diff = dx_press;
         pgr_pkg::DIV_TDY: div_req.diff = dy_press;
         pgr_pkg::DIV_SDX: div_req.diff = dx_move;
         pgr_pkg::DIV_SDY: div_req.diff = dy_move;
      endcase
      div_req.start = (state_ff == S_DIVGO);
      div_req.scale = cfg.scale_nz;
   end

   always_comb begin
      state_in      = state_ff;
      in_op_in      = in_op_ff;
      in_x_in       = in_x_ff;
      in_y_in       = in_y_ff;
      in_t_in       = in_t_ff;
      in_btn_in     = in_btn_ff;
      in_mods_in    = in_mods_ff;
      in_vis_in     = in_vis_ff;
      in_en_in      = in_en_ff;
      in_raw_in     = in_raw_ff;
      pressed_in    = pressed_ff;
      dragging_in   = dragging_ff;
      captured_in   = captured_ff;
      press_x_in    = press_x_ff;
      press_y_in    = press_y_ff;
      move_x_in     = move_x_ff;
      move_y_in     = move_y_ff;
      press_btn_in  = press_btn_ff;
      press_mods_in = press_mods_ff;
      click_t_in    = click_t_ff;
      click_x_in    = click_x_ff;
      click_y_in    = click_y_ff;
      mode_click_in = mode_click_ff;
      start_in      = start_ff;
      k_in          = k_ff;
      qt_in         = qt_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      kind0_in      = kind0_ff;
      kind1_in      = kind1_ff;
      two_in        = two_ff;
      handled_in    = handled_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               in_op_in   = req_opcode;
               in_x_in    = req_pos_x;
               in_y_in    = req_pos_y;
               in_t_in    = req_time_ms;
               in_btn_in  = req_button;
               in_mods_in = req_modifiers;
               in_vis_in  = req_visible;
               in_en_in   = req_enabled;
               in_raw_in  = req_raw_consumed;
               state_in   = S_DECIDE;
            end
         end
         S_DECIDE: begin
            // default outcome: one empty result
            kind0_in   = pgr_pkg::K_NONE;
            two_in     = 1'b0;
            handled_in = 1'b0;
            state_in   = S_EMIT0;
            k_in       = pgr_pkg::DIV_TDX;
            start_in   = 1'b0;
            unique case (in_op_ff)
               pgr_pkg::OP_PRESS: begin
                  if (in_vis_ff && in_en_ff) begin
                     handled_in = 1'b1;
                     if (!in_raw_ff) begin
                        pressed_in    = 1'b1;
                        dragging_in   = 1'b0;
                        captured_in   = 1'b1;
                        press_x_in    = in_x_ff;
                        press_y_in    = in_y_ff;
                        move_x_in     = in_x_ff;
                        move_y_in     = in_y_ff;
                        press_btn_in  = in_btn_ff;
                        press_mods_in = in_mods_ff;
                     end
                  end
               end
               pgr_pkg::OP_MOVE: begin
                  if (in_vis_ff && in_raw_ff) begin
                     handled_in = 1'b1;
                  end else if (in_vis_ff && pressed_ff) begin
                     handled_in    = 1'b1;
                     mode_click_in = 1'b0;
                     state_in      = dragging_ff ? S_DIVGO : S_M0;
                  end
               end
               pgr_pkg::OP_RELEASE: begin
                  if (in_vis_ff && !pressed_ff) begin
                     handled_in = in_raw_ff;
                  end else if (in_vis_ff) begin
                     handled_in = 1'b1;
                     if (dragging_ff) begin
                        state_in = S_DIVGO;
                     end else if (press_btn_ff == pgr_pkg::BTN_RIGHT) begin
                        kind0_in    = pgr_pkg::K_RIGHT;
                        pressed_in  = 1'b0;
                        dragging_in = 1'b0;
                        captured_in = 1'b0;
                     end else if (click_t_ff != 32'd0) begin
                        mode_click_in = 1'b1;
                        state_in      = S_M0;
                     end else begin
                        kind0_in    = pgr_pkg::K_CLICK;
                        click_t_in  = in_t_ff;
                        click_x_in  = in_x_ff;
                        click_y_in  = in_y_ff;
                        pressed_in  = 1'b0;
                        dragging_in = 1'b0;
                        captured_in = 1'b0;
                     end
                  end
               end
               default: begin
                  handled_in = 1'b0;
               end
            endcase
         end
         S_M0: begin
            prod_in  = mul_p;
            state_in = S_M1;
         end
         S_M1: begin
            prod_in  = mul_p;
            acc_in   = prod_ff[32:0];
            state_in = S_M2;
         end
         S_M2: begin
            prod_in  = mul_p;
            acc_in   = acc_ff + prod_ff[32:0];
            state_in = S_M3;
         end
         S_M3: begin
            prod_in  = mul_p;
            state_in = S_M4;
         end
         S_M4: begin
            if (mode_click_ff) begin
               kind0_in    = pgr_pkg::K_CLICK;
               kind1_in    = pgr_pkg::K_DOUBLE;
               two_in      = in_window && hit_click;
               // a double click forgets the first so no triple fires
               if (in_window && hit_click) begin
                  click_t_in = 32'd0;
               end else begin
                  click_t_in = in_t_ff;
                  click_x_in = in_x_ff;
                  click_y_in = in_y_ff;
               end
               pressed_in  = 1'b0;
               dragging_in = 1'b0;
               captured_in = 1'b0;
               state_in    = S_EMIT0;
            end else if (hit_drag) begin
               start_in = 1'b1;
               state_in = S_DIVGO;
            end else begin
               state_in = S_EMIT0;
            end
         end
         S_DIVGO: begin
            state_in = S_DIVWAIT;
         end
         S_DIVWAIT: begin
            if (div_rsp.done) begin
               qt_in[k_ff] = div_rsp.value;
               if (k_ff == k_last) begin
                  state_in = S_FIN;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = S_DIVGO;
               end
            end
         end
         S_FIN: begin
            if (in_op_ff == pgr_pkg::OP_MOVE) begin
               kind0_in    = start_ff ? pgr_pkg::K_DRAG_START : pgr_pkg::K_DRAG;
               kind1_in    = pgr_pkg::K_DRAG;
               two_in      = start_ff;
               dragging_in = 1'b1;
               move_x_in   = in_x_ff;
               move_y_in   = in_y_ff;
            end else begin
               kind0_in    = pgr_pkg::K_DRAG_END;
               two_in      = 1'b0;
               pressed_in  = 1'b0;
               dragging_in = 1'b0;
               captured_in = 1'b0;
            end
            state_in = S_EMIT0;
         end
         S_EMIT0: begin
            if (out_free) begin
               state_in = two_ff ? S_EMIT1 : S_IDLE;
            end
         end
         S_EMIT1: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result payload from the gesture kind
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_kind_in    = rsp_kind_ff;
      rsp_handled_in = rsp_handled_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_sdx_in     = rsp_sdx_ff;
      rsp_sdy_in     = rsp_sdy_ff;
      rsp_tdx_in     = rsp_tdx_ff;
      rsp_tdy_in     = rsp_tdy_ff;
      rsp_btn_in     = rsp_btn_ff;
      rsp_mods_in    = rsp_mods_ff;
      rsp_t_in       = rsp_t_ff;
      if (emit_go) begin
         rsp_valid_in   = 1'b1;
         rsp_kind_in    = emit_kind;
         rsp_handled_in = handled_ff;
         rsp_last_in    = (state_ff == S_EMIT1) || !two_ff;
         rsp_t_in       = in_t_ff;
         rsp_count_in   = pgr_pkg::CNT_NONE;
         rsp_sdx_in     = 16'd0;
         rsp_sdy_in     = 16'd0;
         rsp_tdx_in     = 16'd0;
         rsp_tdy_in     = 16'd0;
         rsp_btn_in     = press_btn_ff;
         rsp_mods_in    = press_mods_ff;
         unique case (emit_kind)
            pgr_pkg::K_NONE: begin
               rsp_btn_in  = 2'd0;
               rsp_mods_in = 4'd0;
            end
            pgr_pkg::K_CLICK, pgr_pkg::K_RIGHT: begin
               rsp_count_in = pgr_pkg::CNT_SINGLE;
               rsp_btn_in   = in_btn_ff;
               rsp_mods_in  = in_mods_ff;
            end
            pgr_pkg::K_DOUBLE: begin
               rsp_count_in = pgr_pkg::CNT_DOUBLE;
               rsp_btn_in   = in_btn_ff;
               rsp_mods_in  = in_mods_ff;
            end
            pgr_pkg::K_DRAG_START: begin
               rsp_sdx_in = qt_ff[pgr_pkg::DIV_TDX];
               rsp_sdy_in = qt_ff[pgr_pkg::DIV_TDY];
               rsp_tdx_in = qt_ff[pgr_pkg::DIV_TDX];
               rsp_tdy_in = qt_ff[pgr_pkg::DIV_TDY];
            end
            pgr_pkg::K_DRAG: begin
               rsp_sdx_in = qt_ff[pgr_pkg::DIV_SDX];
               rsp_sdy_in = qt_ff[pgr_pkg::DIV_SDY];
               rsp_tdx_in = qt_ff[pgr_pkg::DIV_TDX];
               rsp_tdy_in = qt_ff[pgr_pkg::DIV_TDY];
            end
            pgr_pkg::K_DRAG_END: begin
               rsp_tdx_in = qt_ff[pgr_pkg::DIV_TDX];
               rsp_tdy_in = qt_ff[pgr_pkg::DIV_TDY];
            end
            default: begin
               rsp_btn_in  = 2'd0;
               rsp_mods_in = 4'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pressed_ff    <= 1'b0;
         dragging_ff   <= 1'b0;
         captured_ff   <= 1'b0;
         press_x_ff    <= 16'sd0;
         press_y_ff    <= 16'sd0;
         move_x_ff     <= 16'sd0;
         move_y_ff     <= 16'sd0;
         press_btn_ff  <= 2'd0;
         press_mods_ff <= 4'd0;
         click_t_ff    <= 32'd0;
         click_x_ff    <= 16'sd0;
         click_y_ff    <= 16'sd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pressed_ff    <= pressed_in;
         dragging_ff   <= dragging_in;
         captured_ff   <= captured_in;
         press_x_ff    <= press_x_in;
         press_y_ff    <= press_y_in;
         move_x_ff     <= move_x_in;
         move_y_ff     <= move_y_in;
         press_btn_ff  <= press_btn_in;
         press_mods_ff <= press_mods_in;
         click_t_ff    <= click_t_in;
         click_x_ff    <= click_x_in;
         click_y_ff    <= click_y_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      in_op_ff       <= in_op_in;
      in_x_ff        <= in_x_in;
      in_y_ff        <= in_y_in;
      in_t_ff        <= in_t_in;
      in_btn_ff      <= in_btn_in;
      in_mods_ff     <= in_mods_in;
      in_vis_ff      <= in_vis_in;
      in_en_ff       <= in_en_in;
      in_raw_ff      <= in_raw_in;
      mode_click_ff  <= mode_click_in;
      start_ff       <= start_in;
      k_ff           <= k_in;
      qt_ff          <= qt_in;
      prod_ff        <= prod_in;
      acc_ff         <= acc_in;
      kind0_ff       <= kind0_in;
      kind1_ff       <= kind1_in;
      two_ff         <= two_in;
      handled_ff     <= handled_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_handled_ff <= rsp_handled_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_sdx_ff     <= rsp_sdx_in;
      rsp_sdy_ff     <= rsp_sdy_in;
      rsp_tdx_ff     <= rsp_tdx_in;
      rsp_tdy_ff     <= rsp_tdy_in;
      rsp_btn_ff     <= rsp_btn_in;
      rsp_mods_ff    <= rsp_mods_in;
      rsp_t_ff       <= rsp_t_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_kind      = rsp_kind_ff;
   assign rsp_handled         = rsp_handled_ff;
   assign rsp_last_of_run     = rsp_last_ff;
   assign rsp_click_count     = rsp_count_ff;
   assign rsp_step_dx         = rsp_sdx_ff;
   assign rsp_step_dy         = rsp_sdy_ff;
   assign rsp_total_dx        = rsp_tdx_ff;
   assign rsp_total_dy        = rsp_tdy_ff;
   assign rsp_event_button    = rsp_btn_ff;
   assign rsp_event_modifiers = rsp_mods_ff;
   assign rsp_event_time_ms   = rsp_t_ff;

   `PGR_ASSERT_ALWAYS(a_drag_needs_press, !dragging_ff || pressed_ff, "drag active without press")
   `PGR_ASSERT_ALWAYS(a_capture_tracks_press, captured_ff == pressed_ff, "capture out of step")
   `PGR_ASSERT_IMPLY(a_div_done_expected, div_rsp.done, state_ff == S_DIVWAIT, "stray divide done")
   `PGR_ASSERT_IMPLY(a_second_kind, state_ff == S_EMIT1, kind1_ff == pgr_pkg::K_DOUBLE || kind1_ff == pgr_pkg::K_DRAG, "bad second result")

endmodule

/* hdl/pointer_gesture_recognizer.sv */
// Top level of the pointer gesture recognizer.
//
// Turns press, move and release events into click, double click, right click
// and drag results; each event yields one or two results, the last one flagged
// by rsp_last_of_run. One event is in work at a time and req_stall stays high
// until its results are handed to the result register. An event that needs no
// arithmetic goes from the decide state straight to the emit states; a release
// that checks for a double click and a move that tests the drag threshold first
// run the squared-distance check on the shared 24x24 multiplier. Logical deltas
// come from a divider that resolves one quotient bit per cycle, one delta at a
// time: a drag end needs two deltas and a drag move four. A new event is taken
// while the last result still waits in the result register.
module pointer_gesture_recognizer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [31:0]        req_time_ms,
   input  logic [1:0]         req_button,
   input  logic [3:0]         req_modifiers,
   input  logic               req_visible,
   input  logic               req_enabled,
   input  logic               req_raw_consumed,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_event_kind,
   output logic               rsp_handled,
   output logic               rsp_last_of_run,
   output logic [1:0]         rsp_click_count,
   output logic signed [15:0] rsp_step_dx,
   output logic signed [15:0] rsp_step_dy,
   output logic signed [15:0] rsp_total_dx,
   output logic signed [15:0] rsp_total_dy,
   output logic [1:0]         rsp_event_button,
   output logic [3:0]         rsp_event_modifiers,
   output logic [31:0]        rsp_event_time_ms,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   pgr_pkg::cfg_type     cfg;
   pgr_pkg::div_req_type div_req;
   pgr_pkg::div_rsp_type div_rsp;

   pgr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pgr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   pgr_seq u_seq (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_pos_x           (req_pos_x),
      .req_pos_y           (req_pos_y),
      .req_time_ms         (req_time_ms),
      .req_button          (req_button),
      .req_modifiers       (req_modifiers),
      .req_visible         (req_visible),
      .req_enabled         (req_enabled),
      .req_raw_consumed    (req_raw_consumed),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_event_kind      (rsp_event_kind),
      .rsp_handled         (rsp_handled),
      .rsp_last_of_run     (rsp_last_of_run),
      .rsp_click_count     (rsp_click_count),
      .rsp_step_dx         (rsp_step_dx),
      .rsp_step_dy         (rsp_step_dy),
      .rsp_total_dx        (rsp_total_dx),
      .rsp_total_dy        (rsp_total_dy),
      .rsp_event_button    (rsp_event_button),
      .rsp_event_modifiers (rsp_event_modifiers),
      .rsp_event_time_ms   (rsp_event_time_ms),
      .div_req             (div_req),
      .div_rsp             (div_rsp)
   );

endmodule
